// ===== rtl/smd_pkg.sv =====
// Shared constants and types for the soft Manchester decoder.
// No dependencies; compile first.
`default_nettype none

package smd_pkg;

  localparam int THR_WIDTH = 15;
  localparam int TS_WIDTH  = 32;

  typedef logic [THR_WIDTH-1:0] thr_t;
  typedef logic [TS_WIDTH-1:0]  ts_t;

endpackage

`default_nettype wire

// ===== rtl/smd_ifs.sv =====
// Valid/ready channel interfaces: sample input, decoded bit output, threshold write.
// Depends on smd_pkg.
`default_nettype none

interface smd_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  import smd_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  ts_t                            time_stamp;

  modport source (output valid, output sample, output time_stamp, input ready);
  modport sink   (input valid, input sample, input time_stamp, output ready);
endinterface

interface smd_out_if;
  import smd_pkg::*;
  logic valid;
  logic ready;
  logic decoded_bit;
  ts_t  bit_time;

  modport source (output valid, output decoded_bit, output bit_time, input ready);
  modport sink   (input valid, input decoded_bit, input bit_time, output ready);
endinterface

interface smd_cfg_if;
  import smd_pkg::*;
  logic valid;
  logic ready;
  thr_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/soft_manchester_decoder_resync.sv =====
// Soft-decision Manchester decoder with bit phase resync.
// Bit word path: the accepted sample is held in the input reg, then its bit goes to the result reg.
// Throughput: one sample per cycle while the result reg is not stalled; the decision is a single compare stage.
// Zero or one bit per sample; output reg stalls back only through the input reg.
// Reset (sync, rst_n low): history, parity, phase and threshold cleared to zero.
// Depends on smd_pkg and the channel interfaces in smd_ifs.sv.
`default_nettype none

module soft_manchester_decoder_resync #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire           clk,
  input  wire           rst_n,
  smd_in_if.sink        in_ch,
  smd_out_if.source     out_ch,
  smd_cfg_if.sink       cfg_ch
);
  import smd_pkg::*;

  localparam int CW = (SAMPLE_WIDTH > THR_WIDTH) ? SAMPLE_WIDTH : THR_WIDTH;

  typedef logic [SAMPLE_WIDTH-1:0] smp_t;

  // exact magnitude; most negative value maps to 2^(W-1) unsigned
  function automatic smp_t mag(input smp_t x);
    mag = x[SAMPLE_WIDTH-1] ? (~x + smp_t'(1)) : x;
  endfunction

  thr_t thr_r;

  logic s1_valid_r;
  smp_t s1_sample_r;
  ts_t  s1_ts_r;

  smp_t last_r, second_r;
  logic parity_r, phase_r;

  logic out_valid_r;
  logic bit_r;
  ts_t  bit_time_r;

  logic s1_adv;
  logic in_ready;
  smp_t mag_older, mag_prev, mag_cur;
  logic off_phase, resync, phase_nxt, emit, bit_nxt, prev_pos, cur_pos;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    mag_older = mag(second_r);
    mag_prev  = mag(last_r);
    mag_cur   = mag(s1_sample_r);
    off_phase = parity_r != phase_r;
    // magnitude above threshold implies nonzero, so sign match is an msb match
    resync    = off_phase && (second_r[SAMPLE_WIDTH-1] == last_r[SAMPLE_WIDTH-1]) &&
                (CW'(mag_older) > CW'(thr_r)) && (CW'(mag_prev) > CW'(thr_r));
    phase_nxt = resync ? parity_r : phase_r;
    emit      = parity_r == phase_nxt;
    prev_pos  = !last_r[SAMPLE_WIDTH-1] && (last_r != '0);
    cur_pos   = !s1_sample_r[SAMPLE_WIDTH-1] && (s1_sample_r != '0);
    // tie goes to the current half-bit
    bit_nxt   = (mag_prev > mag_cur) ? prev_pos : !cur_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_sample_r <= in_ch.sample;
      s1_ts_r     <= in_ch.time_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      second_r <= '0;
      parity_r <= 1'b0;
      phase_r  <= 1'b0;
    end else if (s1_adv) begin
      second_r <= last_r;
      last_r   <= s1_sample_r;
      parity_r <= !parity_r;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      bit_r      <= bit_nxt;
      bit_time_r <= s1_ts_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.decoded_bit = bit_r;
  assign out_ch.bit_time    = bit_time_r;

  a_par_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (parity_r != $past(parity_r)))
    else $error("parity did not toggle on a processed sample");

  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> ($stable(last_r) && $stable(parity_r) && $stable(phase_r)))
    else $error("decoder state moved without a processed sample");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(s1_adv))
    else $error("result word appeared without a processed sample");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ready)
    else $error("input accepted while the pipeline is blocked");

endmodule

`default_nettype wire

// ===== tb/sv/soft_manchester_decoder_resync_tb.sv =====
// Self-checking bench for the soft Manchester decoder: threshold writes, directed and
// random soft-sample streams, randomized stalls on both sides, bit-by-bit scoreboard.
// Depends on smd_pkg, the channel interfaces in smd_ifs.sv and the decoder RTL.
`timescale 1ns / 100ps

module soft_manchester_decoder_resync_tb;
  import smd_pkg::*;

  localparam int SW          = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 10;

  typedef logic signed [SW-1:0] smp_t;

  // Expected-bit store plus a cycle-free model of the decoder state.
  class BitScoreboard;
    thr_t threshold;
    smp_t prev_smp;
    smp_t older_smp;
    bit   parity;
    bit   phase;
    bit   exp_bit_q[$];
    ts_t  exp_time_q[$];
    int   errors;
    int   bits_checked;
    int   samples_seen;

    function new();
      threshold = '0;
      prev_smp  = '0;
      older_smp = '0;
      parity    = 1'b0;
      phase     = 1'b0;
    endfunction

    function void set_threshold(thr_t v);
      threshold = v;
    endfunction

    function int magnitude(smp_t v);
      return (v < 0) ? -int'(v) : int'(v);
    endfunction

    function int sign_of(smp_t v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function int pending();
      return exp_bit_q.size();
    endfunction

    function void note_sample(smp_t smp, ts_t ts);
      bit b;
      samples_seen++;
      // off-phase: two strong same-sign half-bits pull the phase onto this sample
      if (parity != phase) begin
        if (sign_of(older_smp) == sign_of(prev_smp) &&
            magnitude(older_smp) > int'(threshold) &&
            magnitude(prev_smp) > int'(threshold))
          phase = parity;
      end
      if (parity == phase) begin
        if (magnitude(prev_smp) > magnitude(smp))
          b = (prev_smp > 0);
        else
          b = !(smp > 0);
        exp_bit_q.push_back(b);
        exp_time_q.push_back(ts);
      end
      older_smp = prev_smp;
      prev_smp  = smp;
      parity    = !parity;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40)
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_bit(logic b, ts_t t);
      logic eb;
      ts_t  et;
      if (exp_bit_q.size() == 0) begin
        report($sformatf("unexpected word: bit %0b time %08h", b, t));
        return;
      end
      eb = exp_bit_q.pop_front();
      et = exp_time_q.pop_front();
      bits_checked++;
      if (b !== eb)
        report($sformatf("decoded_bit %0b, want %0b (time %08h)", b, eb, et));
      if (t !== et)
        report($sformatf("bit_time %08h, want %08h", t, et));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  always #2 clk = ~clk;

  smd_in_if #(.SAMPLE_WIDTH(SW)) in_ch ();
  smd_out_if                     out_ch ();
  smd_cfg_if                     cfg_ch ();

  soft_manchester_decoder_resync #(.SAMPLE_WIDTH(SW)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  BitScoreboard sb = new();

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_req      = 1'b0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;
  int   cfg_writes    = 0;
  ts_t  ts_ctr        = '0;

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_req     <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_bit(out_ch.decoded_bit, out_ch.bit_time);
  end

  // Watchdog: any accepted word on any channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no progress for %0d cycles", QUIET_LIMIT);
        $display("[soft_manchester_decoder_resync] ERROR");
        $finish;
      end
    end
  end

  function automatic ts_t next_ts();
    if ($urandom_range(7, 0) == 0)
      ts_ctr = $urandom;
    else
      ts_ctr = ts_ctr + $urandom_range(3, 1);
    return ts_ctr;
  endfunction

  function automatic smp_t rand_sample();
    case ($urandom_range(15, 0))
      0:       return smp_t'(-32768);
      1:       return smp_t'(32767);
      2:       return '0;
      3:       return smp_t'(-1);
      default: return smp_t'($urandom);
    endcase
  endfunction

  // One Manchester half-bit, usually strong enough to count for resync.
  function automatic smp_t half_sample(bit positive);
    int m;
    if ($urandom_range(99, 0) < 8)
      return rand_sample();
    if (sb.threshold == 15'h7fff || $urandom_range(99, 0) < 15)
      m = $urandom_range(32767, 0);
    else
      m = $urandom_range(32767, int'(sb.threshold) + 1);
    if (!positive && (sb.threshold == 15'h7fff || $urandom_range(7, 0) == 0))
      return smp_t'(-32768);
    return positive ? smp_t'(m) : smp_t'(-m);
  endfunction

  task automatic send_sample(smp_t smp, ts_t ts);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= smp;
    in_ch.time_stamp <= ts;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(smp, ts);
  endtask

  task automatic write_threshold(thr_t v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_threshold(v);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  // Let every expected bit drain, then cover the pipeline for samples with no bit.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Mostly Manchester bursts, occasionally slipped by one half-bit; the rest is noise.
  task automatic run_traffic(int n);
    int sent;
    int nbits;
    bit b;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99, 0) < 80) begin
        if ($urandom_range(99, 0) < 15) begin
          send_sample(rand_sample(), next_ts());
          sent++;
        end
        nbits = $urandom_range(12, 2);
        repeat (nbits) begin
          b = bit'($urandom_range(1, 0));
          send_sample(half_sample(b), next_ts());
          send_sample(half_sample(!b), next_ts());
          sent += 2;
        end
      end else begin
        send_sample(rand_sample(), next_ts());
        sent++;
      end
    end
  endtask

  initial begin
    thr_t thr_list[PHASES];
    thr_list = '{15'd0, 15'h7fff, 15'd0, 15'd1000, 15'd12000,
                 15'd0, 15'h7fff, 15'd300, 15'd0, 15'd20000};
    thr_list[2] = thr_t'($urandom);
    thr_list[5] = thr_t'($urandom);
    thr_list[8] = thr_t'($urandom_range(4000, 0));

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.sample     = '0;
    in_ch.time_stamp = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zeros, extremes, ties, same-sign strong pairs
    write_threshold(15'd0);
    send_sample('0, 32'h0000_0000);
    send_sample('0, 32'hffff_ffff);
    send_sample(smp_t'(-32768), 32'haaaa_aaaa);
    send_sample(smp_t'(-32768), 32'h5555_5555);
    send_sample(smp_t'(32767), 32'd1);
    send_sample(smp_t'(-32768), 32'd2);
    send_sample(smp_t'(-1), 32'd3);
    send_sample(smp_t'(1), 32'd4);
    send_sample(smp_t'(100), 32'd5);
    send_sample(smp_t'(-100), 32'd6);
    send_sample(smp_t'(-100), 32'd7);
    send_sample(smp_t'(100), 32'd8);
    send_sample(smp_t'(32767), 32'd9);
    send_sample(smp_t'(32767), 32'd10);
    send_sample(smp_t'(5), 32'd11);
    send_sample(smp_t'(-7), 32'd12);
    wait_idle();
    // max threshold: only the most negative value is strong enough
    write_threshold(15'h7fff);
    send_sample(smp_t'(32767), 32'd13);
    send_sample(smp_t'(32767), 32'd14);
    send_sample(smp_t'(-32768), 32'd15);
    send_sample(smp_t'(-32768), 32'd16);
    send_sample(smp_t'(20), 32'd17);
    send_sample(smp_t'(-20), 32'd18);
    send_sample('0, 32'd19);
    send_sample(smp_t'(1), 32'd20);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 51; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      write_threshold(thr_list[p]);
      if (p == 2)
        hold_req <= 1'b1;   // long sink hold-off while samples keep coming
      run_traffic(55);
      if (p == 5)
        wait_idle();        // sender pause until the pipe is empty
      run_traffic(55);
      wait_idle();
    end

    $display("Run covered %0d samples and %0d decoded bits over %0d threshold writes,",
             sb.samples_seen, sb.bits_checked, cfg_writes);
    $display("with free-running, sender-gapped, sink-stalled and mixed flow phases.");
    if (sb.errors == 0)
      $display("[soft_manchester_decoder_resync] OK");
    else
      $display("[soft_manchester_decoder_resync] ERROR");
    $finish;
  end

endmodule
